### hw/rtl/calibration_scale_statistics_assert.svh
// Assertion macros for the calibration scale statistics block.
// Used by the port checker; needs nothing else.
`ifndef CALIBRATION_SCALE_STATISTICS_ASSERT_SVH
`define CALIBRATION_SCALE_STATISTICS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("calibration_scale_statistics check failed");

// antecedent implies consequent in the next cycle
`define CSS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("calibration_scale_statistics check failed");

`endif

### hw/rtl/cssc_pkg.sv
// Shared constants for the calibration scale statistics block.
// No dependencies.
package cssc_pkg;
  localparam int unsigned SIG_W          = 32;
  localparam int unsigned CNT_VAL_W      = 32;
  localparam int unsigned SCALE_W        = 48;
  localparam int unsigned DVS_W          = 48;
  localparam int unsigned RUN_W          = 7;
  localparam int unsigned PCT_W          = 32;
  localparam int unsigned SCALE_SHIFT    = 24;
  localparam int unsigned SCALE_DVD_W    = SIG_W + SCALE_SHIFT;
  localparam int unsigned DEV100_W       = SCALE_W + 7;
  localparam int unsigned CV_SHIFT       = 16;
  localparam int unsigned CV_DVD_W       = DEV100_W + CV_SHIFT;
  localparam int unsigned MAX_RUNS_DEF   = 64;
  localparam logic [SIG_W-1:0] DEFAULT_SIGNAL = 32'd132164267;
endpackage

### hw/rtl/calibration_scale_statistics.sv
// A kept count uses the shared divider for 56 steps; a zero or excess count skips it.
// The last item adds the mean division (48+log2(MAX_RUNS) steps), states ST_VRD to ST_VM3
// per stored scale for the squared deviations, the variance division (96+log2(MAX_RUNS)
// steps), the square root (half that) and the percent division (71 steps), each when needed.
// Input is stalled while an item is in work; a finished result waits in the output register.
// Reset clears counters, sum and flags; sig_q resets to 2016.667 uV (Q16.16).
module calibration_scale_statistics #(
  parameter int unsigned MAX_RUNS = cssc_pkg::MAX_RUNS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cssc_pkg::SIG_W-1:0]        cfg_data_i,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cssc_pkg::CNT_VAL_W-1:0]    count_value_i,
  input  logic                              last_count_i,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cssc_pkg::SCALE_W-1:0]      mean_scale_o,
  output logic [cssc_pkg::SCALE_W-1:0]      deviation_scale_o,
  output logic [cssc_pkg::PCT_W-1:0]        variation_percent_o,
  output logic [cssc_pkg::RUN_W-1:0]        run_total_o,
  output logic [cssc_pkg::SIG_W-1:0]        effective_signal_o,
  output logic                              status_code_o,
  output logic                              overflow_flag_o
);
  import cssc_pkg::*;

  localparam int unsigned AW    = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RUNS + 1);
  localparam int unsigned SUM_W = SCALE_W + $clog2(MAX_RUNS);
  localparam int unsigned ACC_W = 2 * SCALE_W + $clog2(MAX_RUNS);
  localparam int unsigned DIV_W = ACC_W;
  localparam int unsigned NB_W  = $clog2(DIV_W + 1);
  localparam int unsigned SQ_W  = (DIV_W + 1) / 2;
  localparam int unsigned HW    = SCALE_W / 2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCALE, ST_STAT, ST_MEAN, ST_VRD, ST_VDIF, ST_VM0, ST_VM1,
    ST_VM2, ST_VM3, ST_VDIV, ST_SQRT, ST_CV, ST_CVDIV, ST_OUT
  } state_e;

  state_e             state_q;
  logic [SIG_W-1:0]   sig_q;
  logic [CNT_W-1:0]   kept_q;
  logic [SUM_W-1:0]   sum_q;
  logic               exceeded_q, last_q;
  logic [AW-1:0]      idx_q;
  logic [SCALE_W-1:0] mean_q, dev_q, d_q, rd_q;
  logic [PCT_W-1:0]   cv_q;
  logic [SCALE_W-1:0] p_q;
  logic [ACC_W-1:0]   acc_q;
  logic               div_start_q, sq_start_q;
  logic [DIV_W-1:0]   div_dvd_q;
  logic [NB_W-1:0]    div_nb_q;
  logic [DVS_W-1:0]   div_dvs_q;
  logic               div_done, sq_done;
  logic [DIV_W-1:0]   quo;
  logic [SQ_W-1:0]    root;
  logic [SCALE_W-1:0] mem [MAX_RUNS];

  logic               out_valid_q, status_q, ovf_q;
  logic [SCALE_W-1:0] mean_o_q, dev_o_q;
  logic [PCT_W-1:0]   cv_o_q;
  logic [RUN_W-1:0]   run_o_q;
  logic [SIG_W-1:0]   eff_o_q;

  logic [SCALE_W-1:0]       scale_sat, dev_sat, dhi, dlo;
  logic [DEV100_W-1:0]      dev100;
  logic                     cv_big, out_free;
  logic [CNT_W+RUN_W-1:0]   n_ext;
  logic                     mem_we;
  logic                     last_idx, div_go, sq_go;

  always_comb begin
    scale_sat = (quo[SCALE_DVD_W-1:SCALE_W] != '0) ? '1 : quo[SCALE_W-1:0];
    dev_sat   = (root[SQ_W-1:SCALE_W] != '0) ? '1 : root[SCALE_W-1:0];
    dhi       = SCALE_W'(d_q[SCALE_W-1:HW]);
    dlo       = SCALE_W'(d_q[HW-1:0]);
    dev100    = (DEV100_W'(dev_q) << 6) + (DEV100_W'(dev_q) << 5) + (DEV100_W'(dev_q) << 2);
    cv_big    = {9'd0, dev100} >= {mean_q, 16'd0};
    out_free  = !out_valid_q || !out_stall;
    n_ext     = (CNT_W+RUN_W)'(kept_q);
    mem_we    = (state_q == ST_SCALE) && div_done;
    last_idx  = (CNT_W'(idx_q) + CNT_W'(1) == kept_q);
    div_go    = ((state_q == ST_IDLE) && in_valid && (count_value_i != '0)
                 && (kept_q < CNT_W'(MAX_RUNS)))
             || ((state_q == ST_STAT) && (kept_q != '0))
             || ((state_q == ST_VM3) && last_idx)
             || ((state_q == ST_CV) && (mean_q != '0) && !cv_big);
    sq_go     = (state_q == ST_VDIV) && div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q <= DEFAULT_SIGNAL;
    end else if (cfg_valid) begin
      sig_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[kept_q[AW-1:0]] <= scale_sat;
    end
    if (state_q == ST_VRD) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kept_q      <= '0;
      sum_q       <= '0;
      exceeded_q  <= 1'b0;
      last_q      <= 1'b0;
      idx_q       <= '0;
      mean_q      <= '0;
      dev_q       <= '0;
      d_q         <= '0;
      cv_q        <= '0;
      p_q         <= '0;
      acc_q       <= '0;
      div_start_q <= 1'b0;
      sq_start_q  <= 1'b0;
      div_dvd_q   <= '0;
      div_nb_q    <= '0;
      div_dvs_q   <= '0;
      out_valid_q <= 1'b0;
      mean_o_q    <= '0;
      dev_o_q     <= '0;
      cv_o_q      <= '0;
      run_o_q     <= '0;
      eff_o_q     <= '0;
      status_q    <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      div_start_q <= div_go;
      sq_start_q  <= sq_go;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid) begin
            last_q <= last_count_i;
            if (count_value_i != '0 && kept_q < CNT_W'(MAX_RUNS)) begin
              div_dvd_q   <= {sig_q, {SCALE_SHIFT{1'b0}}, {(DIV_W-SCALE_DVD_W){1'b0}}};
              div_nb_q    <= NB_W'(SCALE_DVD_W);
              div_dvs_q   <= DVS_W'(count_value_i);
              state_q     <= ST_SCALE;
            end else begin
              if (count_value_i != '0) begin
                exceeded_q <= 1'b1;
              end
              if (last_count_i) begin
                state_q <= ST_STAT;
              end
            end
          end
        end
        ST_SCALE: begin
          if (div_done) begin
            sum_q   <= sum_q + SUM_W'(scale_sat);
            kept_q  <= kept_q + CNT_W'(1);
            state_q <= last_q ? ST_STAT : ST_IDLE;
          end
        end
        ST_STAT: begin
          if (kept_q == '0) begin
            mean_q  <= '0;
            dev_q   <= '0;
            cv_q    <= '0;
            state_q <= ST_OUT;
          end else begin
            div_dvd_q   <= {sum_q, {(DIV_W-SUM_W){1'b0}}};
            div_nb_q    <= NB_W'(SUM_W);
            div_dvs_q   <= DVS_W'(kept_q);
            state_q     <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (div_done) begin
            mean_q <= quo[SCALE_W-1:0];
            idx_q  <= '0;
            acc_q  <= '0;
            if (kept_q == CNT_W'(1)) begin
              dev_q   <= '0;
              state_q <= ST_CV;
            end else begin
              state_q <= ST_VRD;
            end
          end
        end
        ST_VRD: begin
          state_q <= ST_VDIF;
        end
        ST_VDIF: begin
          d_q     <= (rd_q >= mean_q) ? rd_q - mean_q : mean_q - rd_q;
          state_q <= ST_VM0;
        end
        ST_VM0: begin
          p_q     <= dlo * dlo;
          state_q <= ST_VM1;
        end
        ST_VM1: begin
          acc_q   <= acc_q + ACC_W'(p_q);
          p_q     <= dhi * dlo;
          state_q <= ST_VM2;
        end
        ST_VM2: begin
          acc_q   <= acc_q + (ACC_W'(p_q) << (HW + 1));
          p_q     <= dhi * dhi;
          state_q <= ST_VM3;
        end
        ST_VM3: begin
          acc_q <= acc_q + (ACC_W'(p_q) << SCALE_W);
          idx_q <= idx_q + AW'(1);
          if (last_idx) begin
            state_q <= ST_VDIV;
            div_dvd_q   <= acc_q + (ACC_W'(p_q) << SCALE_W);
            div_nb_q    <= NB_W'(DIV_W);
            div_dvs_q   <= DVS_W'(kept_q - CNT_W'(1));
          end else begin
            state_q <= ST_VRD;
          end
        end
        ST_VDIV: begin
          if (div_done) begin
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            dev_q   <= dev_sat;
            state_q <= ST_CV;
          end
        end
        ST_CV: begin
          if (mean_q == '0) begin
            cv_q    <= '0;
            state_q <= ST_OUT;
          end else if (cv_big) begin
            cv_q    <= '1;
            state_q <= ST_OUT;
          end else begin
            div_dvd_q   <= {dev100, {CV_SHIFT{1'b0}}, {(DIV_W-CV_DVD_W){1'b0}}};
            div_nb_q    <= NB_W'(CV_DVD_W);
            div_dvs_q   <= mean_q;
            state_q     <= ST_CVDIV;
          end
        end
        ST_CVDIV: begin
          if (div_done) begin
            cv_q    <= quo[PCT_W-1:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            mean_o_q    <= mean_q;
            dev_o_q     <= dev_q;
            cv_o_q      <= cv_q;
            run_o_q     <= n_ext[RUN_W-1:0];
            eff_o_q     <= (sig_q != '0) ? sig_q : DEFAULT_SIGNAL;
            status_q    <= (kept_q == '0);
            ovf_q       <= exceeded_q;
            kept_q      <= '0;
            sum_q       <= '0;
            exceeded_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  cssc_div #(.DVD_W(DIV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dvd_q),
    .steps_i    (div_nb_q),
    .divisor_i  (div_dvs_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  cssc_sqrt #(.RAD_W(DIV_W)) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start_q),
    .radicand_i (quo),
    .done_o     (sq_done),
    .root_o     (root)
  );

  assign cfg_ready           = 1'b1;
  assign in_stall            = (state_q != ST_IDLE);
  assign out_valid           = out_valid_q;
  assign mean_scale_o        = mean_o_q;
  assign deviation_scale_o   = dev_o_q;
  assign variation_percent_o = cv_o_q;
  assign run_total_o         = run_o_q;
  assign effective_signal_o  = eff_o_q;
  assign status_code_o       = status_q;
  assign overflow_flag_o     = ovf_q;
endmodule

### hw/rtl/cssc_div.sv
// Restoring divider, one quotient bit per cycle, 48-bit divisor.
// Depends on cssc_pkg.
module cssc_div #(
  parameter int unsigned DVD_W = 102
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [DVD_W-1:0]                 dividend_i,
  input  logic [$clog2(DVD_W+1)-1:0]       steps_i,
  input  logic [cssc_pkg::DVS_W-1:0]       divisor_i,
  output logic                             done_o,
  output logic [DVD_W-1:0]                 quotient_o
);
  import cssc_pkg::*;

  localparam int unsigned NB_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, quo_q;
  logic [DVS_W-1:0] dvs_q, rem_q, rem_d;
  logic [NB_W-1:0]  cnt_q;
  logic             done_q;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
    rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= steps_i;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - NB_W'(1);
        if (cnt_q == NB_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

### hw/rtl/cssc_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on cssc_pkg.
module cssc_sqrt #(
  parameter int unsigned RAD_W = 102
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [RAD_W-1:0]           radicand_i,
  output logic                       done_o,
  output logic [(RAD_W+1)/2-1:0]     root_o
);
  import cssc_pkg::*;

  localparam int unsigned PAIRS = (RAD_W + 1) / 2;
  localparam int unsigned RW    = PAIRS + 2;
  localparam int unsigned NB_W  = $clog2(PAIRS + 1);

  logic [2*PAIRS-1:0] rad_q;
  logic [RW-1:0]      rem_q, r2, trial, diff, rem_d;
  logic [PAIRS-1:0]   root_q;
  logic [NB_W-1:0]    cnt_q;
  logic               done_q, ge;

  always_comb begin
    r2    = {rem_q[RW-3:0], rad_q[2*PAIRS-1 -: 2]};
    trial = {root_q, 2'b01};
    ge    = r2 >= trial;
    diff  = r2 - trial;
    rem_d = ge ? diff : r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= NB_W'(PAIRS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - NB_W'(1);
        if (cnt_q == NB_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= (2*PAIRS)'(radicand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[2*PAIRS-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[PAIRS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

### hw/rtl/cssc_checker.sv
// Port checker for calibration_scale_statistics, bound to the top level.
// Depends on cssc_pkg and calibration_scale_statistics_assert.svh.
`include "calibration_scale_statistics_assert.svh"
module cssc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [cssc_pkg::SCALE_W-1:0]   mean_scale_o,
  input logic [cssc_pkg::SCALE_W-1:0]   deviation_scale_o,
  input logic [cssc_pkg::PCT_W-1:0]     variation_percent_o,
  input logic [cssc_pkg::RUN_W-1:0]     run_total_o,
  input logic [cssc_pkg::SIG_W-1:0]     effective_signal_o,
  input logic                           status_code_o
);
  import cssc_pkg::*;

  `CSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && out_stall, out_valid && $stable(mean_scale_o) && $stable(variation_percent_o))
  `CSS_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, out_valid && status_code_o, mean_scale_o == '0 && deviation_scale_o == '0 && variation_percent_o == '0 && run_total_o == '0)
  `CSS_ASSERT_IMP(a_zero_mean_cv, clk_i, rst_ni, out_valid && mean_scale_o == '0, variation_percent_o == '0)
  `CSS_ASSERT_IMP(a_eff_nonzero, clk_i, rst_ni, out_valid, effective_signal_o != '0)
endmodule

bind calibration_scale_statistics cssc_checker u_cssc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .mean_scale_o        (mean_scale_o),
  .deviation_scale_o   (deviation_scale_o),
  .variation_percent_o (variation_percent_o),
  .run_total_o         (run_total_o),
  .effective_signal_o  (effective_signal_o),
  .status_code_o       (status_code_o)
);

### bench/tb_calibration_scale_statistics.sv
// Self-checking testbench for calibration_scale_statistics: drives count sets with
// random gaps and output stalls, predicts each set result and compares the whole result.
// Depends on cssc_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_calibration_scale_statistics;
  import cssc_pkg::*;

  localparam int unsigned RUNS_CAP    = MAX_RUNS_DEF;
  localparam int unsigned SETTLE_CYC  = 100;
  localparam int unsigned EXP_DEPTH   = 16;
  localparam logic [47:0] SCALE_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] PCT_MAX     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [SCALE_W-1:0] mean;
    logic [SCALE_W-1:0] dev;
    logic [PCT_W-1:0]   pct;
    logic [RUN_W-1:0]   runs;
    logic [SIG_W-1:0]   signal;
    logic               status;
    logic               ovf;
  } stats_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [SIG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CNT_VAL_W-1:0] count_value_i = '0;
  logic                 last_count_i = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  stats_t               got;

  logic [SIG_W-1:0]     signal_reg;
  logic [SCALE_W-1:0]   scale_mem [RUNS_CAP];
  int unsigned          kept_cnt;
  logic [53:0]          scale_acc;
  logic                 full_seen;
  stats_t               exp_mem [EXP_DEPTH];
  int unsigned          exp_wr = 0;
  int unsigned          exp_rd = 0;
  int unsigned          n_bad = 0;
  bit                   no_gaps = 1'b0;

  calibration_scale_statistics u_dut (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_data_i,
    .in_valid, .in_stall, .count_value_i, .last_count_i,
    .out_valid, .out_stall,
    .mean_scale_o(got.mean), .deviation_scale_o(got.dev), .variation_percent_o(got.pct),
    .run_total_o(got.runs), .effective_signal_o(got.signal),
    .status_code_o(got.status), .overflow_flag_o(got.ovf)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] root128(logic [127:0] v);
    logic [63:0] res, t;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= v) res = t;
    end
    return res;
  endfunction

  function automatic stats_t close_set();
    stats_t      r;
    logic [63:0] mean, d, dev;
    logic [127:0] sq, num;
    r = '0;
    mean = '0;
    dev = '0;
    if (kept_cnt > 0) begin
      mean = {10'd0, scale_acc} / kept_cnt;
      if (kept_cnt > 1) begin
        sq = '0;
        for (int i = 0; i < kept_cnt; i++) begin
          d = (scale_mem[i] >= mean) ? scale_mem[i] - mean : mean - scale_mem[i];
          sq += {64'd0, d} * {64'd0, d};
        end
        dev = root128(sq / (kept_cnt - 1));
        if (dev > SCALE_MAX) dev = SCALE_MAX;
      end
      if (mean != 0) begin
        num = {64'd0, dev} * 128'd6553600;
        if (num >= ({64'd0, mean} << 32)) r.pct = PCT_MAX;
        else r.pct = 32'(num / mean);
      end
    end
    r.mean   = mean[47:0];
    r.dev    = dev[47:0];
    r.runs   = RUN_W'(kept_cnt);
    r.signal = (signal_reg != 0) ? signal_reg : DEFAULT_SIGNAL;
    r.status = (kept_cnt == 0);
    r.ovf    = full_seen;
    return r;
  endfunction

  task automatic take_count(logic [31:0] cnt, logic last);
    logic [63:0] s;
    if (cnt != 0) begin
      if (kept_cnt < RUNS_CAP) begin
        s = ({32'd0, signal_reg} << 24) / cnt;
        if (s > SCALE_MAX) s = SCALE_MAX;
        scale_mem[kept_cnt] = s[47:0];
        scale_acc += s[53:0];
        kept_cnt++;
      end else begin
        full_seen = 1'b1;
      end
    end
    if (last) begin
      exp_mem[exp_wr % EXP_DEPTH] = close_set();
      exp_wr++;
      kept_cnt = 0;
      scale_acc = '0;
      full_seen = 1'b0;
    end
  endtask

  task automatic send_count(logic [31:0] cnt, logic last);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    count_value_i <= cnt;
    last_count_i  <= last;
    do @(posedge clk_i); while (in_stall);
    take_count(cnt, last);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_signal(logic [31:0] v);
    wait_idle();
    cfg_valid  <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready);
    signal_reg = v;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3, 4:    return $urandom_range(1, 4095);
      5:       return $urandom_range(32'h100, 32'hFFFF) << 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(int unsigned n);
    for (int i = 0; i < n; i++) send_count(rand_count(), i == n - 1);
  endtask

  task automatic test_field_extremes();
    send_count(32'd1, 1'b1);
    send_count(32'hFFFF_FFFF, 1'b0);
    send_count(32'd1, 1'b0);
    send_count(32'd0, 1'b1);
    send_count(32'd0, 1'b1);
    send_count(32'd256, 1'b0);
    send_count(32'd256, 1'b1);
    send_count(32'd300, 1'b0);
    send_count(32'd0, 1'b0);
    send_count(32'd7000, 1'b1);
  endtask

  task automatic test_signal_settings();
    write_signal(32'hFFFF_FFFF);
    send_count(32'd1, 1'b0);
    send_count(32'd3, 1'b1);
    write_signal(32'd0);
    send_count(32'd5, 1'b0);
    send_count(32'd9, 1'b1);
    write_signal(32'd1);
    send_count(32'd1, 1'b0);
    send_count(32'hFFFF_FFFF, 1'b1);
    write_signal(DEFAULT_SIGNAL);
  endtask

  task automatic test_store_full();
    for (int i = 0; i < RUNS_CAP + 3; i++) send_count($urandom_range(1, 9999), 1'b0);
    send_count(32'd0, 1'b1);
  endtask

  task automatic test_drained_pause();
    send_set(4);
    wait_idle();
    send_set(3);
  endtask

  task automatic test_random_sets();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < 2000) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 19))
        0:       n = $urandom_range(RUNS_CAP - 2, RUNS_CAP + 6);
        1, 2:    n = $urandom_range(12, 40);
        default: n = $urandom_range(1, 8);
      endcase
      send_set(n);
      sent += n;
      if ($urandom_range(0, 24) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_signal(32'd0);
          1:       write_signal(32'hFFFF_FFFF);
          default: write_signal($urandom);
        endcase
      end
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk_i) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) out_stall <= 1'b0;
    else if (r < 97) out_stall <= 1'b1;
    else begin
      out_stall <= 1'b1;
      repeat ($urandom_range(10, 40)) @(posedge clk_i);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %p", got);
      end else begin
        e = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (e !== got) begin
          n_bad++;
          if (n_bad <= 10) $display("result differs: expected %p actual %p", e, got);
        end
      end
    end
  end

  initial begin
    signal_reg = DEFAULT_SIGNAL;
    kept_cnt   = 0;
    scale_acc  = '0;
    full_seen  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_field_extremes();
    test_signal_settings();
    test_store_full();
    test_drained_pause();
    test_random_sets();
    wait_idle();
    if (n_bad == 0 && exp_wr == exp_rd) $display("calibration_scale_statistics: match");
    else $display("calibration_scale_statistics: mismatch");
    $finish;
  end

  initial begin
    #100ms;
    $display("calibration_scale_statistics: mismatch");
    $finish;
  end

endmodule
